// ----- sv/ba_pkg.sv -----
// Shared types and constants of the bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package ba_pkg;

    localparam int MAP_WORDS_DEF = 32;
    localparam int WORD_BITS_DEF = 32;

    localparam int IDX_W = 10;
    localparam int WIU_W = 6;
    localparam logic [WIU_W-1:0] WIU_RESET = 6'd32;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_TEST  = 2'd2,
        REQ_FIND  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type        req_type;
        logic [IDX_W-1:0] unit_index;
    } t_req;

    typedef struct packed {
        logic             bit_is_set;
        logic [IDX_W-1:0] free_index;
        logic             free_found;
        logic             out_of_range;
    } t_res;

endpackage

`default_nettype wire

// ----- sv/ba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bitmap_allocator.sv -----
// Top level of the bitmap allocator: request sequencer, map RAM and word summary.
//
//  Channel   Signals                      Direction  Handshake
//  request   start, i_req                 in         taken when start && !busy
//  result    o_done, o_res                out        o_done high for one cycle
//  config    i_cfg_we, i_cfg_data         in         written when i_cfg_we
//
// An accepted request passes in turn through decode (range check or summary
// search), registered map RAM read and modify/write-back; busy is high in
// those states and the result strobe follows in the cycle after write-back.
// A new request is not taken until busy falls again. Reset is synchronous;
// map words read as zero until first written through per-word valid
// flip-flops, so no clearing pass is needed. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_allocator #(
    parameter int MAP_WORDS = ba_pkg::MAP_WORDS_DEF,
    parameter int WORD_BITS = ba_pkg::WORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire ba_pkg::t_req              i_req,
    output logic                           o_done,
    output ba_pkg::t_res                   o_res,
    input  wire logic                      i_cfg_we,
    input  wire logic [ba_pkg::WIU_W-1:0]  i_cfg_data
);

    // Only words below 63 can ever be in use, since the register is 6 bits.
    localparam int ACC_WORDS = (MAP_WORDS < 63) ? MAP_WORDS : 63;
    localparam int AW        = (ACC_WORDS > 1) ? $clog2(ACC_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int QW        = $clog2(1023 / WORD_BITS + 1);
    localparam int RECIP     = 65536 / WORD_BITS;
    localparam int RW        = $clog2(RECIP + 1);
    localparam int PW        = ba_pkg::IDX_W + RW;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_READ   = 4'b0100,
        S_MODIFY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    ba_pkg::t_req                r_req;
    logic [ba_pkg::WIU_W-1:0]    r_wiu;
    logic [QW-1:0]               r_qest;
    logic [AW-1:0]               r_word;
    logic [BW-1:0]               r_bit;
    logic                        r_oor;
    logic                        r_hit;
    logic [ACC_WORDS-1:0]        r_full;
    logic [ACC_WORDS-1:0]        r_valid;
    ba_pkg::t_res                r_res;
    logic                        r_done;

    logic [PW-1:0]               prod;
    logic [ba_pkg::WIU_W-1:0]    live;
    logic [ACC_WORDS-1:0]        avail;
    logic [ba_pkg::IDX_W:0]      rem_est;
    logic [ba_pkg::IDX_W:0]      rem_fix;
    logic [6:0]                  quot;
    logic [WORD_BITS-1:0]        rd_data;
    logic [WORD_BITS-1:0]        cur_word;
    logic [WORD_BITS-1:0]        new_word;
    logic                        ram_we;
    logic [11:0]                 flat_idx;

    function automatic logic [AW-1:0] first_one(input logic [ACC_WORDS-1:0] v);
        logic [AW-1:0] pos;
        pos = '0;
        for (int k = ACC_WORDS - 1; k >= 0; k--) begin
            if (v[k]) pos = AW'(k);
        end
        return pos;
    endfunction

    function automatic logic [BW-1:0] first_zero(input logic [WORD_BITS-1:0] v);
        logic [BW-1:0] pos;
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!v[k]) pos = BW'(k);
        end
        return pos;
    endfunction

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    assign live = (r_wiu > ba_pkg::WIU_W'(ACC_WORDS)) ? ba_pkg::WIU_W'(ACC_WORDS) : r_wiu;

    // The reciprocal estimate of index / WORD_BITS is low by at most one.
    assign prod = PW'(i_req.unit_index) * PW'(RECIP);

    always_comb begin
        rem_est = (ba_pkg::IDX_W + 1)'(r_req.unit_index)
                - (ba_pkg::IDX_W + 1)'(r_qest * (ba_pkg::IDX_W + 1)'(WORD_BITS));
        if (rem_est >= (ba_pkg::IDX_W + 1)'(WORD_BITS)) begin
            rem_fix = rem_est - (ba_pkg::IDX_W + 1)'(WORD_BITS);
            quot    = 7'(r_qest) + 7'd1;
        end else begin
            rem_fix = rem_est;
            quot    = 7'(r_qest);
        end
    end

    always_comb begin
        for (int k = 0; k < ACC_WORDS; k++) begin
            avail[k] = !r_full[k] && (k < int'(live));
        end
    end

    assign cur_word = r_valid[r_word] ? rd_data : '0;

    always_comb begin
        new_word = cur_word;
        if (r_req.req_type == ba_pkg::REQ_SET) begin
            new_word[r_bit] = 1'b1;
        end else begin
            new_word[r_bit] = 1'b0;
        end
    end

    assign ram_we = (r_state == S_MODIFY) && !r_oor
                 && (r_req.req_type == ba_pkg::REQ_SET || r_req.req_type == ba_pkg::REQ_CLEAR);

    assign flat_idx = 12'(r_word) * 12'(WORD_BITS) + 12'(first_zero(cur_word));

    ba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ACC_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (new_word),
        .i_re    (r_state == S_READ),
        .i_raddr (r_word),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_DECODE;
            S_DECODE: n_state = S_READ;
            S_READ:   n_state = S_MODIFY;
            S_MODIFY: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wiu   <= ba_pkg::WIU_RESET;
            r_full  <= '0;
            r_valid <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_MODIFY);
            if (i_cfg_we) begin
                r_wiu <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[r_word] <= 1'b1;
                r_full[r_word]  <= &new_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req  <= i_req;
            r_qest <= QW'(prod >> 16);
        end
        if (r_state == S_DECODE) begin
            if (r_req.req_type == ba_pkg::REQ_FIND) begin
                r_oor  <= 1'b0;
                r_hit  <= |avail;
                r_word <= first_one(avail);
                r_bit  <= '0;
            end else begin
                r_oor  <= (quot >= 7'(live));
                r_hit  <= 1'b0;
                r_word <= AW'(quot);
                r_bit  <= BW'(rem_fix);
            end
        end
        if (r_state == S_MODIFY) begin
            r_res.out_of_range <= r_oor;
            r_res.bit_is_set   <= (r_req.req_type == ba_pkg::REQ_TEST) && !r_oor
                                && cur_word[r_bit];
            r_res.free_found   <= (r_req.req_type == ba_pkg::REQ_FIND) && r_hit;
            r_res.free_index   <= ((r_req.req_type == ba_pkg::REQ_FIND) && r_hit)
                                ? flat_idx[ba_pkg::IDX_W-1:0] : '0;
        end
    end

    a_done_after_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY) |=> o_done)
        else $error("result strobe missing after write-back cycle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$past(o_done))
        else $error("result strobe held for more than one cycle");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_res.out_of_range && (o_res.free_found || o_res.bit_is_set)))
        else $error("out-of-range result carries a hit flag");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

`default_nettype wire

// ----- verif/bitmap_allocator_test.sv -----
// Self-checking testbench for the bitmap allocator: directed and random request streams.
`timescale 1ns / 1ps

module bitmap_allocator_test;
    import ba_pkg::*;

    localparam int WORDS          = MAP_WORDS_DEF;
    localparam int BITS           = WORD_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    t_req                 i_req      = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [WIU_W-1:0]     i_cfg_data = '0;
    logic                 busy;
    logic                 o_done;
    t_res                 o_res;

    // Shadow copy of the allocator state.
    logic [BITS-1:0]      shadow_map [WORDS];
    logic [WIU_W-1:0]     shadow_words;

    t_res                 pending_results [$];
    t_res                 oldest;
    int                   req_count;
    int                   res_count;
    int                   err_count;
    int                   full_finds;
    int                   oor_count;
    int                   cfg_count;
    int                   burst_left;
    int                   idle_cycles;

    bitmap_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int live_words();
        return (shadow_words > WORDS) ? WORDS : int'(shadow_words);
    endfunction

    // Applies one request to the shadow map and returns the result it must produce.
    function automatic t_res apply_to_map(t_req req);
        t_res res;
        int   live;
        int   w;
        int   b;
        int   flat;
        res  = '0;
        live = live_words();
        if (req.req_type == REQ_FIND) begin
            for (w = 0; w < live && !res.free_found; w++) begin
                if (shadow_map[w] != '1) begin
                    for (b = 0; b < BITS; b++) begin
                        if (!shadow_map[w][b]) begin
                            flat = w * BITS + b;
                            res.free_index = flat[IDX_W-1:0];
                            res.free_found = 1'b1;
                            break;
                        end
                    end
                end
            end
            if (!res.free_found)
                full_finds++;
        end else begin
            w = int'(req.unit_index) / BITS;
            b = int'(req.unit_index) % BITS;
            if (w >= live) begin
                res.out_of_range = 1'b1;
                oor_count++;
            end else begin
                case (req.req_type)
                    REQ_SET:   shadow_map[w][b] = 1'b1;
                    REQ_CLEAR: shadow_map[w][b] = 1'b0;
                    default:   res.bit_is_set = shadow_map[w][b];
                endcase
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
        $display("MISMATCH result %0d %s: expected %0h, got %0h", res_count, field, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result", '0, '1);
            end else begin
                oldest = pending_results.pop_front();
                if (o_res.bit_is_set !== oldest.bit_is_set)
                    report_mismatch("bit_is_set", oldest.bit_is_set, o_res.bit_is_set);
                if (o_res.free_index !== oldest.free_index)
                    report_mismatch("free_index", oldest.free_index, o_res.free_index);
                if (o_res.free_found !== oldest.free_found)
                    report_mismatch("free_found", oldest.free_found, o_res.free_found);
                if (o_res.out_of_range !== oldest.out_of_range)
                    report_mismatch("out_of_range", oldest.out_of_range, o_res.out_of_range);
            end
            res_count++;
        end
    end

    // Ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
            $display("bitmap_allocator verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly random gaps, with occasional back-to-back bursts.
    function automatic int pick_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 16);
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken.
    task automatic send_request(t_req req, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_to_map(req));
        req_count++;
    endtask

    task automatic issue(t_req_type op, int unit);
        t_req req;
        req.req_type   = op;
        req.unit_index = unit[IDX_W-1:0];
        send_request(req, pick_gap());
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_words_in_use(logic [WIU_W-1:0] value);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow_words = value;
        i_cfg_we <= 1'b0;
        cfg_count++;
    endtask

    task automatic test_power_up_state();
        issue(REQ_FIND, 0);
        issue(REQ_TEST, 1023);
        issue(REQ_SET, 0);
        issue(REQ_SET, 31);
        issue(REQ_SET, 32);
        issue(REQ_SET, 1023);
        issue(REQ_TEST, 31);
        issue(REQ_TEST, 1023);
        issue(REQ_FIND, 1023);
        issue(REQ_CLEAR, 0);
        issue(REQ_FIND, 512);
        issue(REQ_TEST, 0);
    endtask

    task automatic test_range_limits();
        // With no words in use every indexed request is out of range.
        write_words_in_use(6'd0);
        issue(REQ_SET, 5);
        issue(REQ_CLEAR, 1023);
        issue(REQ_TEST, 0);
        issue(REQ_FIND, 0);
        write_words_in_use(6'd1);
        issue(REQ_SET, 30);
        issue(REQ_SET, 33);
        issue(REQ_TEST, 32);
        issue(REQ_TEST, 31);
        issue(REQ_FIND, 0);
    endtask

    task automatic test_register_saturation();
        // Values above the map size behave as the full map.
        write_words_in_use(6'd63);
        issue(REQ_TEST, 1023);
        issue(REQ_CLEAR, 1023);
        write_words_in_use(6'd33);
        issue(REQ_TEST, 1000);
        issue(REQ_SET, 1000);
    endtask

    task automatic test_random_traffic();
        int  phase_words [8] = '{1, 2, 32, 0, 63, 3, 17, 32};
        int  phase_items [8] = '{120, 140, 330, 60, 180, 120, 180, 70};
        int  span;
        int  cursor;
        int  roll;
        int  pause_at;
        int  unit;
        t_req_type op;
        for (int p = 0; p < 8; p++) begin
            write_words_in_use(phase_words[p][WIU_W-1:0]);
            span     = live_words() * BITS;
            cursor   = 0;
            pause_at = $urandom_range(phase_items[p] / 4, 3 * phase_items[p] / 4);
            for (int i = 0; i < phase_items[p]; i++) begin
                if (i == pause_at)
                    wait_for_results();
                roll = $urandom_range(0, 99);
                if (span == 0 || roll >= 92) begin
                    op   = t_req_type'($urandom_range(0, 3));
                    unit = $urandom_range(0, 1023);
                end else if (roll < 50) begin
                    // Filling from the bottom pushes the lowest free bit upward.
                    op = REQ_SET;
                    if ($urandom_range(0, 1)) begin
                        unit   = cursor;
                        cursor = (cursor + 1) % span;
                    end else begin
                        unit = $urandom_range(0, span - 1);
                    end
                end else if (roll < 62) begin
                    op   = REQ_CLEAR;
                    unit = $urandom_range(0, span - 1);
                end else if (roll < 76) begin
                    op   = REQ_TEST;
                    unit = $urandom_range(0, span - 1);
                end else begin
                    op   = REQ_FIND;
                    unit = $urandom_range(0, 1023);
                end
                issue(op, unit);
            end
        end
    endtask

    initial begin
        foreach (shadow_map[w]) shadow_map[w] = '0;
        shadow_words = WIU_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up_state();
        test_range_limits();
        test_register_saturation();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests under %0d word-count settings; %0d results checked.",
                 req_count, cfg_count, res_count);
        $display("Finds on a full map: %0d, out-of-range requests: %0d.", full_finds, oor_count);
        if (err_count == 0) begin
            $display("bitmap_allocator verification clean");
        end else begin
            $display("bitmap_allocator verification failed");
        end
        $finish;
    end

endmodule
